@@ rtl/core/uclp_pkg.sv @@
// Shared constants for the serial command line parser core.
// No dependencies; imported by the core and its checker.
`default_nettype none

package uclp_pkg;

  // Default line limit: the character that would be number LINE_MAX is dropped
  localparam int LINE_MAX_DEF = 20;

  // Saturation point of the parsed magnitude
  localparam int MAG_W = 14;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Command kinds
  localparam logic [2:0] KIND_HELP   = 3'd0;
  localparam logic [2:0] KIND_DUTY   = 3'd1;
  localparam logic [2:0] KIND_PERIOD = 3'd2;
  localparam logic [2:0] KIND_ANGLE  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;
  localparam logic [2:0] KIND_NONE   = 3'd5;

  // Characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_9     = 8'h39;

  // Output item layout
  localparam int ARG_W   = 15;
  localparam int TDATA_W = 32;

endpackage

`default_nettype wire

@@ rtl/core/uart_command_line_parser_core.sv @@
// Serial command line parser core: echo, line assembly, classification, atoi.
// Depends on uclp_pkg.
// The result item of an accepted input item is registered and shows on m_* in the next cycle.
// Throughput: one item per cycle; the result register is reloaded in the same
//   cycle it is taken, so s_tready only drops while a result is stalled.
// Every input item yields exactly one result item.
// Reset (rst, synchronous, active high) empties the result register and clears
//   the line, the header characters, the number state and the CR/LF flag.
`default_nettype none

module uart_command_line_parser_core
  import uclp_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input stream
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,  // [7:0] rx_byte
  // result stream
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,  // [7:0] echo_byte, [10:8] command_kind,
                                            // [25:11] argument_value, [26] line_overflow,
                                            // [31:27] zero
  output logic                    m_tlast   // line_done
);

  localparam int LEN_W = $clog2(LINE_MAX);

  // number parser phases
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  // line state
  logic [7:0]       first_char, first_char_next;
  logic [7:0]       second_char, second_char_next;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic             skip_lf, skip_lf_next;
  logic [1:0]       number_phase, number_phase_next;
  logic             number_negative, number_negative_next;
  logic [MAG_W-1:0] number_magnitude, number_magnitude_next;

  // result register
  logic [7:0]       echo_byte;
  logic             line_done, line_done_next;
  logic [2:0]       command_kind, command_kind_next;
  logic [ARG_W-1:0] argument_value, argument_value_next;
  logic             line_overflow, line_overflow_next;

  logic             accept;
  logic             is_lf, is_cr, is_digit, is_space, is_sign;
  logic             consumed;
  logic             two_hdr, len_ge3;
  logic [MAG_W+3:0] mag_x10;
  logic [ARG_W-1:0] arg_mag;

  // result register acts as the stage between the two sides
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign is_lf    = (s_tdata == CH_LF);
  assign is_cr    = (s_tdata == CH_CR);
  assign is_digit = (s_tdata >= CH_0) && (s_tdata <= CH_9);
  assign is_space = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
                    (s_tdata == CH_VT) || (s_tdata == CH_FF);
  assign is_sign  = (s_tdata == CH_MINUS) || (s_tdata == CH_PLUS);

  // magnitude * 10 + digit, as shift-and-add
  assign mag_x10 = ({4'b0, number_magnitude} << 3) + ({4'b0, number_magnitude} << 1)
                 + {{(MAG_W){1'b0}}, s_tdata[3:0]};

  assign two_hdr = (line_length >= LEN_W'(2)) && (second_char == CH_SPACE);
  assign len_ge3 = (line_length >= LEN_W'(3));
  assign arg_mag = len_ge3 ? {1'b0, number_magnitude} : '0;

  always_comb begin
    first_char_next       = first_char;
    second_char_next      = second_char;
    line_length_next      = line_length;
    skip_lf_next          = skip_lf;
    number_phase_next     = number_phase;
    number_negative_next  = number_negative;
    number_magnitude_next = number_magnitude;
    line_done_next        = 1'b0;
    command_kind_next     = KIND_HELP;
    argument_value_next   = '0;
    line_overflow_next    = 1'b0;
    consumed              = 1'b0;

    if (is_lf && skip_lf) begin
      // LF of a CR LF pair
      skip_lf_next = 1'b0;
    end else if (is_lf || is_cr) begin
      if (is_cr) begin
        skip_lf_next = 1'b1;
      end
      if (line_length != '0) begin
        line_done_next = 1'b1;
        if (two_hdr && first_char == CH_1 && line_length == LEN_W'(5)) begin
          command_kind_next = KIND_DUTY;
        end else if (two_hdr && first_char == CH_2 && line_length == LEN_W'(6)) begin
          command_kind_next = KIND_PERIOD;
        end else if (two_hdr && first_char == CH_3 && line_length == LEN_W'(5)) begin
          command_kind_next = KIND_ANGLE;
        end else if (line_length == LEN_W'(1) && first_char == CH_4) begin
          command_kind_next = KIND_READ;
        end else if (line_length == LEN_W'(1) && first_char == CH_0) begin
          command_kind_next = KIND_HELP;
        end else begin
          command_kind_next = KIND_NONE;
        end
        argument_value_next   = (number_negative && len_ge3) ? (~arg_mag + ARG_W'(1))
                                                             : arg_mag;
        line_length_next      = '0;
        number_phase_next     = PH_SKIP;
        number_negative_next  = 1'b0;
        number_magnitude_next = '0;
      end
    end else if (line_length < LEN_W'(LINE_MAX - 1)) begin
      if (line_length == '0) begin
        first_char_next = s_tdata;
      end else if (line_length == LEN_W'(1)) begin
        second_char_next = s_tdata;
      end else begin
        // atoi, one character at a time
        if (number_phase == PH_SKIP) begin
          if (is_space) begin
            consumed = 1'b1;
          end else if (is_sign) begin
            number_negative_next = (s_tdata == CH_MINUS);
            number_phase_next    = PH_DIGITS;
            consumed             = 1'b1;
          end else begin
            number_phase_next = is_digit ? PH_DIGITS : PH_STOP;
          end
        end
        if (!consumed && number_phase_next == PH_DIGITS) begin
          if (is_digit) begin
            number_magnitude_next = (mag_x10 > {4'b0, MAG_MAX}) ? MAG_MAX
                                                                 : mag_x10[MAG_W-1:0];
          end else begin
            number_phase_next = PH_STOP;
          end
        end
      end
      line_length_next = line_length + LEN_W'(1);
      skip_lf_next     = 1'b0;
    end else begin
      // too long: drop the line
      line_length_next      = '0;
      number_phase_next     = PH_SKIP;
      number_negative_next  = 1'b0;
      number_magnitude_next = '0;
      skip_lf_next          = 1'b0;
      line_overflow_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_char       <= '0;
      second_char      <= '0;
      line_length      <= '0;
      skip_lf          <= 1'b0;
      number_phase     <= PH_SKIP;
      number_negative  <= 1'b0;
      number_magnitude <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        first_char       <= first_char_next;
        second_char      <= second_char_next;
        line_length      <= line_length_next;
        skip_lf          <= skip_lf_next;
        number_phase     <= number_phase_next;
        number_negative  <= number_negative_next;
        number_magnitude <= number_magnitude_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload of the result register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_byte      <= s_tdata;
      line_done      <= line_done_next;
      command_kind   <= command_kind_next;
      argument_value <= argument_value_next;
      line_overflow  <= line_overflow_next;
    end
  end

  assign m_tdata = {{(TDATA_W - 12 - ARG_W){1'b0}}, line_overflow, argument_value,
                    command_kind, echo_byte};
  assign m_tlast = line_done;

endmodule

`default_nettype wire

@@ rtl/core/uclp_checker.sv @@
// Port-level checks for the command line parser core, bound to the core module.
// Depends on uclp_pkg.
`default_nettype none

module uclp_checker
  import uclp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic [7:0]         s_tdata,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic               m_tlast
);

  // each accepted item shows up next cycle with its echo
  a_echo: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (m_tvalid && m_tdata[7:0] == $past(s_tdata)))
    else $error("result missing or echo wrong");

  // kind and argument are zero unless a line is done
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[10:8] == KIND_HELP && m_tdata[25:11] == '0))
    else $error("fields set without line_done");

  // a finished line and an overflow never come together; kind stays in range
  a_done_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!(m_tlast && m_tdata[26]) && m_tdata[10:8] <= KIND_NONE))
    else $error("bad result flags");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind uart_command_line_parser_core uclp_checker u_uclp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
